// ===== sv/pss_pkg.sv =====
// Shared constants for the positional sequence store: capacity, field widths,
// operation and status codes. No dependencies.
package pss_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int FUNC_W = 2;
   localparam int POS_W  = 9;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 9;

   // common width for comparing a position against the count
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_GET    = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== sv/positional_sequence_store.sv =====
// Throughput: one request at a time; insert and remove move one stored entry per
// cycle through the entry memory, which has separate read and write ports.
// Reset (synchronous): empties the sequence and drops any pending beat; the entry
// memory is not cleared, since only written positions are ever read.
module positional_sequence_store import pss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [POS_W-1:0]         req_pos,
   input  logic signed [DATA_W-1:0] req_elem,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [LEN_W-1:0]         rsp_length
);

   typedef enum logic [2:0] {
      S_IDLE, S_MOVE, S_PLACE, S_READ, S_FETCH, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [DATA_W-1:0]  elem_ff, elem_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0]   moves_ff, moves_in;
   logic               pend_ff, pend_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   logic [DATA_W-1:0]  mem [CAPACITY];
   logic [DATA_W-1:0]  mem_rd_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_wa, mem_ra;
   logic [DATA_W-1:0]  mem_wd;

   logic [CMP_W-1:0]   pos_x, cnt_x;
   logic               pos_zero;

   assign pos_x    = CMP_W'(req_pos);
   assign cnt_x    = CMP_W'(count_ff);
   assign pos_zero = (req_pos == '0);

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_length = rsp_length_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      elem_in       = elem_ff;
      base_in       = base_ff;
      rd_addr_in    = rd_addr_ff;
      wr_addr_in    = wr_addr_ff;
      moves_in      = moves_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = wr_addr_ff;
      mem_ra        = rd_addr_ff;
      mem_wd        = mem_rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               elem_in       = req_elem;
               base_in       = ADDR_W'(pos_x - CMP_W'(1));
               res_status_in = ST_DONE;
               res_value_in  = '0;
               pend_in       = 1'b0;
               state_in      = S_DONE;
               case (req_func)
                  FN_INSERT: begin
                     if (pos_zero || pos_x > cnt_x + CMP_W'(1)) begin
                        res_status_in = ST_RANGE;
                     end else if (cnt_x >= CMP_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // walk from the top entry down to the insert point
                        moves_in   = CNT_W'(cnt_x - pos_x + CMP_W'(1));
                        rd_addr_in = ADDR_W'(cnt_x - CMP_W'(1));
                        state_in   = S_MOVE;
                     end
                  end
                  FN_REMOVE: begin
                     if (pos_zero || pos_x > cnt_x) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        // walk from the entry after the hole up to the top
                        moves_in   = CNT_W'(cnt_x - pos_x);
                        rd_addr_in = ADDR_W'(pos_x);
                        state_in   = S_MOVE;
                     end
                  end
                  FN_GET: begin
                     if (pos_zero || pos_x > cnt_x) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     res_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // write back the word read last cycle, one slot over
            mem_we = pend_ff;
            if (moves_ff != '0) begin
               mem_re   = 1'b1;
               moves_in = moves_ff - CNT_W'(1);
               pend_in  = 1'b1;
               if (func_ff == FN_INSERT) begin
                  wr_addr_in = rd_addr_ff + ADDR_W'(1);
                  rd_addr_in = rd_addr_ff - ADDR_W'(1);
               end else begin
                  wr_addr_in = rd_addr_ff - ADDR_W'(1);
                  rd_addr_in = rd_addr_ff + ADDR_W'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (func_ff == FN_INSERT) begin
                     state_in = S_PLACE;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_PLACE: begin
            mem_we   = 1'b1;
            mem_wa   = base_ff;
            mem_wd   = elem_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_READ: begin
            mem_re   = 1'b1;
            mem_ra   = base_ff;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            res_value_in = mem_rd_ff;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_length_in = LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      elem_ff       <= elem_in;
      base_ff       <= base_in;
      rd_addr_ff    <= rd_addr_in;
      wr_addr_ff    <= wr_addr_in;
      moves_ff      <= moves_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

endmodule

// ===== sv/pss_checker.sv =====
// Port-level checks for positional_sequence_store, attached by bind.
// Depends on pss_pkg for widths, capacity and status codes.
module pss_checker import pss_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [STAT_W-1:0]        rsp_status,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic [LEN_W-1:0]         rsp_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_value) && $stable(rsp_length))
      else $error("result beat changed while stalled");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_value == '0)
      else $error("nonzero value on a failed request");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == LEN_W'(CAPACITY))
      else $error("full status while store not at capacity");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("beat or busy survives reset");

endmodule

bind positional_sequence_store pss_checker u_pss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_value  (rsp_value),
   .rsp_length (rsp_length)
);

// ===== dv/tb_positional_sequence_store.sv =====
// Self-checking testbench for positional_sequence_store: directed and random
// insert/remove/get traffic, checked beat by beat against a queue-based predictor.
// Depends on pss_pkg and the positional_sequence_store RTL.
`timescale 1ns / 100ps

module tb_positional_sequence_store;
   import pss_pkg::*;

   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
   localparam int IDLE_PCT  = 29;
   localparam int LIMIT     = 1_200_000;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] value;
      logic [LEN_W-1:0]         length;
   } rsp_beat_type;

   class store_scoreboard_type;
      logic signed [DATA_W-1:0] held_values[$];
      rsp_beat_type             expected_rsp[$];
      int                       failures = 0;

      function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] elem);
         rsp_beat_type r;
         int           p;
         int           n;
         p = int'(pos);
         n = held_values.size();
         r.status = ST_DONE;
         r.value  = '0;
         case (func)
            FN_INSERT: begin
               // position is checked ahead of fullness
               if (p < 1 || p > n + 1) r.status = ST_RANGE;
               else if (n >= CAPACITY) r.status = ST_FULL;
               else held_values.insert(p - 1, elem);
            end
            FN_REMOVE: begin
               if (p < 1 || p > n) r.status = ST_RANGE;
               else held_values.delete(p - 1);
            end
            FN_GET: begin
               if (p < 1 || p > n) r.status = ST_RANGE;
               else r.value = held_values[p - 1];
            end
            default: r.status = ST_RANGE;
         endcase
         r.length = LEN_W'(held_values.size());
         expected_rsp.push_back(r);
      endfunction

      function void check_response(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] value,
                                   logic [LEN_W-1:0] length);
         rsp_beat_type e;
         if (expected_rsp.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("unexpected beat: status %0d value %0d length %0d",
                        status, value, length);
            return;
         end
         e = expected_rsp.pop_front();
         if (status !== e.status || value !== e.value || length !== e.length) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("mismatch: expected status %0d value %0d length %0d, got %0d %0d %0d",
                        e.status, e.value, e.length, status, value, length);
         end
      endfunction
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func  = FN_INSERT;
   logic [POS_W-1:0]         req_pos   = '0;
   logic signed [DATA_W-1:0] req_elem  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_value;
   logic [LEN_W-1:0]         rsp_length;

   bit                   idle_en = 1'b1;
   int                   cycles  = 0;
   store_scoreboard_type sb;

   positional_sequence_store u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_pos    (req_pos),
      .req_elem   (req_elem),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_length (rsp_length)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_value, rsp_length);
         rsp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] func, input int pos,
                               input logic [DATA_W-1:0] elem);
      while (idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_pos   <= POS_W'(pos);
      req_elem  <= elem;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, POS_W'(pos), elem);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_elem();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed positions, a share of raw noise over the full field range
   task automatic mixed_burst(input int items, input int ins_pct, input int rem_pct);
      int r;
      int n;
      for (int k = 0; k < items; k++) begin
         n = sb.held_values.size();
         r = $urandom_range(99);
         if ($urandom_range(99) < 8)
            send_request(FUNC_W'($urandom_range(3)), $urandom_range(511), $urandom);
         else if (r < ins_pct)
            send_request(FN_INSERT, $urandom_range(n + 1, 1), pick_elem());
         else if (r < ins_pct + rem_pct)
            send_request(FN_REMOVE, $urandom_range(n, 1), $urandom);
         else
            send_request(FN_GET, $urandom_range(n, 1), $urandom);
      end
   endtask

   initial begin
      int n;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, edges of the position range, head/middle/tail
      send_request(FN_GET,    1, 32'h0);
      send_request(FN_REMOVE, 1, 32'h0);
      send_request(FN_INSERT, 0, 32'h1234_5678);
      send_request(FN_INSERT, 2, 32'h1234_5678);
      send_request(FN_INSERT, 1, 32'h7fff_ffff);
      send_request(FN_INSERT, 2, 32'h8000_0000);
      send_request(FN_INSERT, 1, 32'hffff_ffff);
      send_request(FN_INSERT, 2, 32'h0000_0000);
      for (int p = 1; p <= 4; p++) send_request(FN_GET, p, 32'h0);
      send_request(FN_GET,    5,   32'h0);
      send_request(FN_GET,    0,   32'h0);
      send_request(FN_GET,    511, 32'hffff_ffff);
      send_request(FN_UNUSED, 1,   32'hffff_ffff);
      send_request(FN_REMOVE, 0,   32'h0);
      send_request(FN_REMOVE, 5,   32'h0);
      send_request(FN_REMOVE, 4,   32'h0);
      send_request(FN_REMOVE, 1,   32'h0);
      send_request(FN_GET,    1,   32'h0);
      send_request(FN_GET,    2,   32'h0);
      send_request(FN_REMOVE, 511, 32'h0);
      wait_drained();

      mixed_burst(80, 50, 20);
      wait_drained();

      // fill to capacity with no idling on either side, then probe the full store
      idle_en = 1'b0;
      while (sb.held_values.size() < CAPACITY) begin
         n = sb.held_values.size();
         send_request(FN_INSERT, ($urandom_range(3) == 0) ? $urandom_range(n + 1, 1) : n + 1,
                      pick_elem());
      end
      send_request(FN_INSERT, 1,            $urandom);
      send_request(FN_INSERT, CAPACITY + 1, $urandom);
      send_request(FN_INSERT, CAPACITY + 2, $urandom);
      send_request(FN_INSERT, 0,            $urandom);
      send_request(FN_GET,    CAPACITY,     32'h0);
      send_request(FN_GET,    CAPACITY + 1, 32'h0);
      send_request(FN_REMOVE, CAPACITY,     32'h0);
      idle_en = 1'b1;
      wait_drained();

      mixed_burst(80, 20, 65);
      while (sb.held_values.size() > 0)
         send_request(FN_REMOVE, $urandom_range(sb.held_values.size(), 1), $urandom);
      wait_drained();

      mixed_burst(80, 45, 30);
      wait_drained();
      repeat (CAPACITY + 16) @(posedge clock);

      if (sb.expected_rsp.size() != 0) sb.failures++;
      if (sb.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== positional_sequence_store.f =====
sv/pss_pkg.sv
sv/positional_sequence_store.sv
sv/pss_checker.sv
dv/tb_positional_sequence_store.sv
